>>> hdl/lps_pkg.sv
// Shared constants, types and helpers of the RGB LED pulse serializer.
`default_nettype none
package lps_pkg;

	localparam int BITS_PER_PIXEL = 24;
	localparam int PIXEL_W        = 24;
	localparam int COLOR_W        = 8;
	localparam int TICK_W         = 6;
	localparam int CNT_W          = $clog2(BITS_PER_PIXEL + 1);
	localparam int CFG_IDX_W      = 3;
	localparam int QUEUE_DEPTH    = 2;
	localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

	localparam logic [TICK_W-1:0] ONE_HIGH_RST  = TICK_W'(18);
	localparam logic [TICK_W-1:0] ONE_LOW_RST   = TICK_W'(5);
	localparam logic [TICK_W-1:0] ZERO_HIGH_RST = TICK_W'(5);
	localparam logic [TICK_W-1:0] ZERO_LOW_RST  = TICK_W'(18);

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ONE_HIGH  = 3'd0,
		REG_ONE_LOW   = 3'd1,
		REG_ZERO_HIGH = 3'd2,
		REG_ZERO_LOW  = 3'd3
	} cfg_reg_t;

	// Classified item as it travels from the front end to the back end.
	typedef struct packed {
		logic               is_tick;
		logic [PIXEL_W-1:0] pixel;
	} lps_cmd_t;

	typedef struct packed {
		logic line_level;
		logic busy_res;
		logic pixel_done;
		logic load_refused;
	} lps_res_t;

	// A phase time of zero still lasts one tick.
	function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] t);
		return (t == '0) ? TICK_W'(1) : t;
	endfunction

endpackage
`default_nettype wire

>>> hdl/lps_ifs.sv
// Handshake interfaces for pixel items, result items and configuration writes.
`default_nettype none
interface lps_in_if;
	import lps_pkg::*;
	logic               valid;
	logic               ready;
	logic               action;
	logic [COLOR_W-1:0] red;
	logic [COLOR_W-1:0] green;
	logic [COLOR_W-1:0] blue;
	modport source (output valid, output action, output red, output green, output blue,
		input ready);
	modport sink (input valid, input action, input red, input green, input blue,
		output ready);
endinterface

interface lps_out_if;
	logic valid;
	logic ready;
	logic line_level;
	logic busy_res;
	logic pixel_done;
	logic load_refused;
	modport source (output valid, output line_level, output busy_res, output pixel_done,
		output load_refused, input ready);
	modport sink (input valid, input line_level, input busy_res, input pixel_done,
		input load_refused, output ready);
endinterface

interface lps_cfg_if;
	import lps_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [TICK_W-1:0]    data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> hdl/lps_front.sv
// Front end: accepts items, classifies them and packs the pixel word in send order.
`default_nettype none
module lps_front (
	lps_in_if.sink             pix,
	output logic               push,
	output lps_pkg::lps_cmd_t  push_cmd,
	input  logic               full
);
	import lps_pkg::*;

	assign pix.ready = !full;
	assign push      = pix.valid && !full;

	// Green goes out first, then red, then blue, each MSB first.
	always_comb begin
		push_cmd.is_tick = (pix.action == ACT_TICK);
		push_cmd.pixel   = {pix.green, pix.red, pix.blue};
	end

endmodule
`default_nettype wire

>>> hdl/lps_queue.sv
// Short queue that decouples the front end from the waveform engine.
`default_nettype none
module lps_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  lps_pkg::lps_cmd_t  push_cmd,
	output logic               full,
	input  logic               pop,
	output logic               head_valid,
	output lps_pkg::lps_cmd_t  head_cmd
);
	import lps_pkg::*;

	lps_cmd_t          entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count exceeds depth");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

>>> hdl/lps_back.sv
// Back end: timing registers, bit waveform engine and the result register.
`default_nettype none
module lps_back (
	input  logic               clk,
	input  logic               arst_n,
	lps_cfg_if.sink            cfg,
	input  logic               head_valid,
	input  lps_pkg::lps_cmd_t  head_cmd,
	output logic               pop,
	lps_out_if.source          res
);
	import lps_pkg::*;

	logic [TICK_W-1:0]  one_high_q, one_low_q, zero_high_q, zero_low_q;
	logic [PIXEL_W-1:0] shift_q, shift_nx;
	logic [CNT_W-1:0]   remaining_q, remaining_nx;
	logic               high_q, high_nx;
	logic [TICK_W-1:0]  ticks_q, ticks_nx, ticks_dec;
	logic               res_valid_q;
	lps_res_t           res_q, res_nx;
	logic               busy;

	function automatic logic [TICK_W-1:0] pick_time(input logic b,
		input logic [TICK_W-1:0] one_t, input logic [TICK_W-1:0] zero_t);
		return at_least_one(b ? one_t : zero_t);
	endfunction

	assign cfg.ready = 1'b1;
	assign pop       = head_valid && (!res_valid_q || res.ready);
	assign busy      = (remaining_q != '0);
	assign ticks_dec = (ticks_q != '0) ? ticks_q - 1'b1 : ticks_q;

	always_comb begin
		shift_nx     = shift_q;
		remaining_nx = remaining_q;
		high_nx      = high_q;
		ticks_nx     = ticks_q;
		res_nx       = '0;
		if (!head_cmd.is_tick) begin
			if (busy) begin
				res_nx.load_refused = 1'b1;
				res_nx.line_level   = high_q;
			end else begin
				shift_nx     = head_cmd.pixel;
				remaining_nx = CNT_W'(BITS_PER_PIXEL);
				high_nx      = 1'b1;
				ticks_nx     = pick_time(head_cmd.pixel[PIXEL_W-1], one_high_q, zero_high_q);
			end
		end else if (busy) begin
			res_nx.line_level = high_q;
			ticks_nx          = ticks_dec;
			if (ticks_dec == '0) begin
				if (high_q) begin
					high_nx  = 1'b0;
					ticks_nx = pick_time(shift_q[PIXEL_W-1], one_low_q, zero_low_q);
				end else begin
					// Bits past the pixel word shift in as zero bits.
					shift_nx     = {shift_q[PIXEL_W-2:0], 1'b0};
					remaining_nx = remaining_q - 1'b1;
					if (remaining_q == CNT_W'(1)) begin
						res_nx.pixel_done = 1'b1;
						ticks_nx          = '0;
					end else begin
						high_nx  = 1'b1;
						ticks_nx = pick_time(shift_q[PIXEL_W-2], one_high_q, zero_high_q);
					end
				end
			end
		end
		res_nx.busy_res = (remaining_nx != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			one_high_q  <= ONE_HIGH_RST;
			one_low_q   <= ONE_LOW_RST;
			zero_high_q <= ZERO_HIGH_RST;
			zero_low_q  <= ZERO_LOW_RST;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_ONE_HIGH:  one_high_q  <= cfg.data;
				REG_ONE_LOW:   one_low_q   <= cfg.data;
				REG_ZERO_HIGH: zero_high_q <= cfg.data;
				REG_ZERO_LOW:  zero_low_q  <= cfg.data;
				default:       ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q     <= '0;
			remaining_q <= '0;
			high_q      <= 1'b0;
			ticks_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				shift_q     <= shift_nx;
				remaining_q <= remaining_nx;
				high_q      <= high_nx;
				ticks_q     <= ticks_nx;
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_nx;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.line_level   = res_q.line_level;
	assign res.busy_res     = res_q.busy_res;
	assign res.pixel_done   = res_q.pixel_done;
	assign res.load_refused = res_q.load_refused;

`ifndef ASSERT_OFF
	a_idle_low: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !high_q)
		else $error("high phase while idle");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop && res_nx.pixel_done |=> !busy && res.valid)
		else $error("pixel done left engine busy");
	a_refuse_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.load_refused |-> res.busy_res)
		else $error("refused load reported while idle");
`endif

endmodule
`default_nettype wire

>>> hdl/rgb_led_pulse_serializer.sv
// Top level of the RGB LED pulse serializer.
// Each result item comes from the result register after its item has passed through the queue.
// Throughput: one item per cycle while the result receiver is ready.
// A two-entry queue separates acceptance from the engine; a result register drives out.
// Reset clears queue, engine state and result valid, and loads default timings.
`default_nettype none
module rgb_led_pulse_serializer (
	input  logic       clk,
	input  logic       arst_n,
	lps_in_if.sink     pix,
	lps_out_if.source  res,
	lps_cfg_if.sink    cfg
);
	import lps_pkg::*;

	logic     push, full, pop, head_valid;
	lps_cmd_t push_cmd, head_cmd;

	lps_front u_front (
		.pix      (pix),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full)
	);

	lps_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	lps_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.res        (res)
	);

endmodule
`default_nettype wire

>>> bench/tb_rgb_led_pulse_serializer.sv
// Self-checking testbench for the RGB LED pulse serializer: timed pixel waveforms against a predictor.
module tb_rgb_led_pulse_serializer;
	import lps_pkg::*;

	localparam int HOLD_CYCLES = 60;
	localparam int SETTLE_CYCLES = 8;
	localparam logic [CFG_IDX_W-1:0] SPARE_REG_IDX = 3'd6;

	typedef struct packed {
		logic               action;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} pixel_item_t;

	typedef struct {
		pixel_item_t item;
		bit          typed;
		lps_res_t    want;
	} step_row_t;

	localparam lps_res_t RES_IDLE    = '{1'b0, 1'b0, 1'b0, 1'b0};
	localparam lps_res_t RES_LOADED  = '{1'b0, 1'b1, 1'b0, 1'b0};
	localparam lps_res_t RES_REFUSED = '{1'b1, 1'b1, 1'b0, 1'b1};

	logic clk;
	logic arst_n;

	lps_in_if  pix_if();
	lps_out_if res_if();
	lps_cfg_if cfg_if();

	rgb_led_pulse_serializer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix_if),
		.res    (res_if),
		.cfg    (cfg_if)
	);

	// Predicted waveform state and timing registers.
	logic [TICK_W-1:0]  timing [8];
	logic [PIXEL_W-1:0] shift_word;
	logic [CNT_W-1:0]   bits_left;
	logic               high_phase;
	logic [TICK_W-1:0]  ticks_left;

	lps_res_t  pending_results[$];
	step_row_t directed_rows[$];

	int  errors;
	int  items_sent;
	int  pixels_done;
	int  refusals;
	int  input_stall_cycles;
	bit  steady;
	bit  hold_req;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic logic [TICK_W-1:0] phase_len(input bit high);
		logic [TICK_W-1:0] t;
		if (shift_word[PIXEL_W-1])
			t = high ? timing[REG_ONE_HIGH] : timing[REG_ONE_LOW];
		else
			t = high ? timing[REG_ZERO_HIGH] : timing[REG_ZERO_LOW];
		return (t == '0) ? TICK_W'(1) : t;
	endfunction

	task automatic predict_waveform(input pixel_item_t it, output lps_res_t r);
		r = RES_IDLE;
		if (it.action == ACT_LOAD) begin
			if (bits_left != '0) begin
				r.load_refused = 1'b1;
				r.line_level = high_phase;
			end else begin
				shift_word = {it.green, it.red, it.blue};
				bits_left = CNT_W'(BITS_PER_PIXEL);
				high_phase = 1'b1;
				ticks_left = phase_len(1'b1);
			end
		end else if (bits_left != '0) begin
			r.line_level = high_phase;
			if (ticks_left != '0)
				ticks_left = ticks_left - 1'b1;
			if (ticks_left == '0) begin
				if (high_phase) begin
					high_phase = 1'b0;
					ticks_left = phase_len(1'b0);
				end else begin
					// Bits past the pixel word shift in as zero bits.
					shift_word = shift_word << 1;
					bits_left = bits_left - 1'b1;
					if (bits_left == '0) begin
						r.pixel_done = 1'b1;
						ticks_left = '0;
					end else begin
						high_phase = 1'b1;
						ticks_left = phase_len(1'b1);
					end
				end
			end
		end
		r.busy_res = (bits_left != '0);
	endtask

	// Mostly back-to-back, sometimes a short gap, rarely a long pause.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [COLOR_W-1:0] pick_color();
		logic [COLOR_W-1:0] patterns [8];
		patterns = '{8'h00, 8'hFF, 8'hF0, 8'h0F, 8'hCC, 8'h33, 8'hAA, 8'h55};
		if ($urandom_range(0, 3) == 0)
			return patterns[$urandom_range(0, 7)];
		return COLOR_W'($urandom);
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance with valid left high.
	task automatic offer_item(input pixel_item_t it, input bit typed, input lps_res_t want);
		int n;
		lps_res_t r;
		n = gap_len();
		if (n > 0) begin
			pix_if.valid = 1'b0;
			repeat (n) @(negedge clk);
		end
		pix_if.valid = 1'b1;
		pix_if.action = it.action;
		pix_if.red = it.red;
		pix_if.green = it.green;
		pix_if.blue = it.blue;
		do @(posedge clk); while (pix_if.ready !== 1'b1);
		predict_waveform(it, r);
		pending_results.push_back(typed ? want : r);
		items_sent++;
		if (r.pixel_done)
			pixels_done++;
		if (r.load_refused)
			refusals++;
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] val);
		cfg_if.valid = 1'b1;
		cfg_if.index = idx;
		cfg_if.data = val;
		do @(posedge clk); while (cfg_if.ready !== 1'b1);
		if (idx <= REG_ZERO_LOW)
			timing[idx] = val;
		@(negedge clk);
	endtask

	task automatic load_timings(input logic [TICK_W-1:0] one_hi, input logic [TICK_W-1:0] one_lo,
			input logic [TICK_W-1:0] zero_hi, input logic [TICK_W-1:0] zero_lo,
			input bit spare_too);
		write_reg(REG_ONE_HIGH, one_hi);
		write_reg(REG_ONE_LOW, one_lo);
		write_reg(REG_ZERO_HIGH, zero_hi);
		write_reg(REG_ZERO_LOW, zero_lo);
		// Writes past the last register must leave the timings alone.
		if (spare_too)
			write_reg(SPARE_REG_IDX, TICK_W'(63));
		cfg_if.valid = 1'b0;
	endtask

	task automatic run_random(input int count);
		pixel_item_t it;
		for (int k = 0; k < count; k++) begin
			if (bits_left == '0)
				it.action = ($urandom_range(0, 1) == 0) ? ACT_LOAD : ACT_TICK;
			else
				it.action = ($urandom_range(0, 24) == 0) ? ACT_LOAD : ACT_TICK;
			it.red = pick_color();
			it.green = pick_color();
			it.blue = pick_color();
			offer_item(it, 1'b0, RES_IDLE);
		end
	endtask

	// Drains the results, shortens the phases so the tail of the pixel in flight
	// takes few items, ticks until that pixel has ended, then waits for every result.
	task automatic finish_pixel();
		pixel_item_t it;
		pix_if.valid = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		load_timings(TICK_W'(1), TICK_W'(1), TICK_W'(1), TICK_W'(1), 1'b0);
		while (bits_left != '0) begin
			it.action = ACT_TICK;
			it.red = pick_color();
			it.green = pick_color();
			it.blue = pick_color();
			offer_item(it, 1'b0, RES_IDLE);
		end
		pix_if.valid = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic add_row(input logic act, input logic [COLOR_W-1:0] r, input logic [COLOR_W-1:0] g,
			input logic [COLOR_W-1:0] b, input bit typed, input lps_res_t want);
		step_row_t row;
		row.item = '{act, r, g, b};
		row.typed = typed;
		row.want = want;
		directed_rows.push_back(row);
	endtask

	// Result checker.
	always @(posedge clk) begin
		lps_res_t want;
		lps_res_t got;
		string names [4];
		names = '{"load_refused", "pixel_done", "busy_res", "line_level"};
		if (arst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
			got = '{res_if.line_level, res_if.busy_res, res_if.pixel_done, res_if.load_refused};
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result item, got %b", $time, got);
			end else begin
				want = pending_results.pop_front();
				for (int i = 0; i < 4; i++)
					if (got[i] !== want[i]) begin
						errors++;
						$display("%0t: %s expected %b got %b", $time, names[i], want[i], got[i]);
					end
			end
		end
	end

	always @(posedge clk)
		if (arst_n && pix_if.valid && pix_if.ready !== 1'b1)
			input_stall_cycles++;

	// Result receiver with random stalls and one long hold-off on request.
	initial begin
		res_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				res_if.ready = 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_req = 1'b0;
			end else if (!steady && $urandom_range(0, 3) == 0) begin
				res_if.ready = 1'b0;
				repeat (gap_len()) @(negedge clk);
			end else begin
				res_if.ready = 1'b1;
			end
		end
	end

	initial begin
		#5_000_000;
		$display("rgb_led_pulse_serializer: mismatch");
		$finish;
	end

	initial begin
		errors = 0;
		items_sent = 0;
		pixels_done = 0;
		refusals = 0;
		input_stall_cycles = 0;
		steady = 1'b0;
		hold_req = 1'b0;
		arst_n = 1'b0;
		pix_if.valid = 1'b0;
		pix_if.action = ACT_TICK;
		pix_if.red = '0;
		pix_if.green = '0;
		pix_if.blue = '0;
		cfg_if.valid = 1'b0;
		cfg_if.index = REG_ONE_HIGH;
		cfg_if.data = '0;
		timing[REG_ONE_HIGH] = ONE_HIGH_RST;
		timing[REG_ONE_LOW] = ONE_LOW_RST;
		timing[REG_ZERO_HIGH] = ZERO_HIGH_RST;
		timing[REG_ZERO_LOW] = ZERO_LOW_RST;
		shift_word = '0;
		bits_left = '0;
		high_phase = 1'b0;
		ticks_left = '0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed steps at the reset timings.
		add_row(ACT_TICK, 8'h00, 8'h00, 8'h00, 1'b1, RES_IDLE);
		add_row(ACT_TICK, 8'hFF, 8'hFF, 8'hFF, 1'b1, RES_IDLE);
		add_row(ACT_LOAD, 8'h00, 8'hFF, 8'h00, 1'b1, RES_LOADED);
		add_row(ACT_LOAD, 8'hFF, 8'hFF, 8'hFF, 1'b1, RES_REFUSED);
		for (int k = 0; k < 6; k++)
			add_row(ACT_TICK, 8'hAA, 8'h55, 8'hCC, 1'b0, RES_IDLE);
		add_row(ACT_LOAD, 8'hF0, 8'h0F, 8'h33, 1'b1, RES_REFUSED);
		add_row(ACT_TICK, 8'h00, 8'h00, 8'h00, 1'b0, RES_IDLE);
		foreach (directed_rows[i])
			offer_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
		finish_pixel();

		// Shortest timings, no idling on either side.
		steady = 1'b1;
		load_timings(TICK_W'(1), TICK_W'(1), TICK_W'(1), TICK_W'(1), 1'b0);
		run_random(100);
		finish_pixel();
		steady = 1'b0;

		// Small random timings with a long receiver hold-off.
		load_timings(TICK_W'($urandom_range(1, 8)), TICK_W'($urandom_range(1, 8)),
			TICK_W'($urandom_range(1, 8)), TICK_W'($urandom_range(1, 8)), 1'b0);
		hold_req = 1'b1;
		run_random(100);
		finish_pixel();

		load_timings(TICK_W'(63), TICK_W'(1), TICK_W'(1), TICK_W'(63), 1'b0);
		run_random(60);
		finish_pixel();

		// Zero timings act as one tick; the spare index write is ignored.
		load_timings('0, '0, '0, '0, 1'b1);
		run_random(100);
		finish_pixel();

		load_timings(TICK_W'(1), TICK_W'(63), TICK_W'(63), TICK_W'(1), 1'b0);
		run_random(60);
		finish_pixel();

		load_timings(TICK_W'($urandom_range(1, 12)), TICK_W'($urandom_range(1, 12)),
			TICK_W'($urandom_range(1, 12)), TICK_W'($urandom_range(1, 12)), 1'b0);
		run_random(100);
		finish_pixel();

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Sent %0d items over seven timing settings: %0d pixels finished, %0d loads refused.",
			items_sent, pixels_done, refusals);
		$display("Input was held back for %0d cycles; %0d field mismatches.",
			input_stall_cycles, errors);
		if (errors == 0)
			$display("rgb_led_pulse_serializer: match");
		else
			$display("rgb_led_pulse_serializer: mismatch");
		$finish;
	end

endmodule

>>> sim.f
hdl/lps_pkg.sv
hdl/lps_ifs.sv
hdl/lps_front.sv
hdl/lps_queue.sv
hdl/lps_back.sv
hdl/rgb_led_pulse_serializer.sv
bench/tb_rgb_led_pulse_serializer.sv
